// ===== design/aip_pkg.sv =====
package aip_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 7;
    localparam int WIDE_W      = VALUE_W + RADIX_W + 1;
    localparam int INC_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = RADIX_W;
    localparam int IN_TDATA_W  = CHAR_W;
    localparam int RESULT_W    = VALUE_W + 2 + COUNT_BITS;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_AUTO    = RADIX_W'(0);
    localparam logic [RADIX_W-1:0] RADIX_OCT     = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_DEC     = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_HEX     = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] NO_DIGIT      = DIGIT_W'(99);
    localparam logic [VALUE_W-1:0] U_MAX         = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] S_MAX         = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] S_MIN_MAG     = 32'h8000_0000;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'b1;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic                    negative;
        logic [VALUE_W-1:0]      accumulator;
        logic [RADIX_W-1:0]      work_radix;
        logic                    overflowed;
        logic                    seen_digit;
        logic [COUNT_BITS-1:0]   char_count;
    } parse_state_t;

    // value sits in the low bits so the struct maps straight onto tdata
    typedef struct packed {
        logic [COUNT_BITS-1:0]   consumed;
        logic                    any_digits;
        logic                    overflow;
        logic [VALUE_W-1:0]      value;
    } result_t;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_W'(c - CH_ZERO);
        else if (c >= CH_UA && c <= CH_UZ)
            d = DIGIT_W'(c - CH_UA + 8'd10);
        else if (c >= CH_LA && c <= CH_LZ)
            d = DIGIT_W'(c - CH_LA + 8'd10);
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
    endfunction

endpackage

// ===== design/aip_step.sv =====
module aip_step (
    input  aip_pkg::parse_state_t             st,
    input  logic [aip_pkg::CHAR_W-1:0]        char_in,
    input  logic                              first,
    input  logic [aip_pkg::RADIX_W-1:0]       radix,
    input  logic                              signed_mode,
    output aip_pkg::parse_state_t             st_next,
    output logic                              res_valid,
    output aip_pkg::result_t                  res
);

    aip_pkg::parse_state_t                cur;
    logic [aip_pkg::RADIX_W-1:0]          r_clamp;
    logic [aip_pkg::RADIX_W-1:0]          base_radix;
    logic [aip_pkg::RADIX_W-1:0]          dr;
    logic [aip_pkg::DIGIT_W-1:0]          d;
    logic [aip_pkg::INC_W-1:0]            inc;
    logic                                 take;
    logic                                 numstart;
    logic [aip_pkg::VALUE_W-1:0]          limit;
    logic [aip_pkg::WIDE_W-1:0]           wide;
    logic [aip_pkg::COUNT_BITS:0]         cnt_sum;
    logic [aip_pkg::VALUE_W-1:0]          fin_value;

    always_comb
    begin
        cur = st;
        if (first)
        begin
            cur.phase       = aip_pkg::PH_SPACE;
            cur.negative    = 1'b0;
            cur.accumulator = '0;
            cur.overflowed  = 1'b0;
            cur.seen_digit  = 1'b0;
            cur.char_count  = '0;
        end

        st_next   = cur;
        take      = 1'b0;
        numstart  = 1'b0;
        res_valid = 1'b0;
        inc       = '0;
        dr        = cur.work_radix;
        d         = aip_pkg::digit_of(char_in);
        r_clamp   = (radix > aip_pkg::RADIX_MAX) ? aip_pkg::RADIX_MAX : radix;
        base_radix = (r_clamp == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_DEC : r_clamp;

        unique case (cur.phase)
            aip_pkg::PH_SPACE:
            begin
                if (aip_pkg::is_space(char_in))
                    inc = aip_pkg::INC_W'(1);
                else if (char_in == aip_pkg::CH_MINUS || char_in == aip_pkg::CH_PLUS)
                begin
                    st_next.negative = (char_in == aip_pkg::CH_MINUS);
                    inc              = aip_pkg::INC_W'(1);
                    st_next.phase    = aip_pkg::PH_SIGN;
                end
                else
                    numstart = 1'b1;
            end
            aip_pkg::PH_SIGN:
                numstart = 1'b1;
            aip_pkg::PH_ZERO, aip_pkg::PH_DIGITS:
            begin
                if (cur.phase == aip_pkg::PH_ZERO &&
                    (char_in == aip_pkg::CH_LX || char_in == aip_pkg::CH_UX))
                begin
                    st_next.work_radix = aip_pkg::RADIX_HEX;
                    st_next.phase      = aip_pkg::PH_HEXPFX;
                end
                else
                begin
                    st_next.phase = aip_pkg::PH_DIGITS;
                    if (d < aip_pkg::DIGIT_W'(cur.work_radix))
                    begin
                        take = 1'b1;
                        inc  = aip_pkg::INC_W'(1);
                    end
                    else
                        res_valid = 1'b1;
                end
            end
            aip_pkg::PH_HEXPFX:
            begin
                if (d < aip_pkg::DIGIT_W'(aip_pkg::RADIX_HEX))
                begin
                    take          = 1'b1;
                    dr            = aip_pkg::RADIX_HEX;
                    inc           = aip_pkg::INC_W'(2);
                    st_next.phase = aip_pkg::PH_DIGITS;
                end
                else
                    res_valid = 1'b1;
            end
            default: ;
        endcase

        // start of the number proper: optional leading zero, else first digit
        if (numstart)
        begin
            if (char_in == aip_pkg::CH_ZERO &&
                (r_clamp == aip_pkg::RADIX_AUTO || r_clamp == aip_pkg::RADIX_HEX))
            begin
                st_next.work_radix = (r_clamp == aip_pkg::RADIX_AUTO) ?
                                     aip_pkg::RADIX_OCT : aip_pkg::RADIX_HEX;
                st_next.seen_digit = 1'b1;
                inc                = aip_pkg::INC_W'(1);
                st_next.phase      = aip_pkg::PH_ZERO;
            end
            else
            begin
                st_next.work_radix = base_radix;
                if (d < aip_pkg::DIGIT_W'(base_radix))
                begin
                    take          = 1'b1;
                    dr            = base_radix;
                    inc           = aip_pkg::INC_W'(1);
                    st_next.phase = aip_pkg::PH_DIGITS;
                end
                else
                    res_valid = 1'b1;
            end
        end

        // fold one digit; range test on the full multiply-add result
        if (signed_mode)
            limit = cur.negative ? aip_pkg::S_MIN_MAG : aip_pkg::S_MAX;
        else
            limit = aip_pkg::U_MAX;
        wide = aip_pkg::WIDE_W'(cur.accumulator) * aip_pkg::WIDE_W'(dr)
             + aip_pkg::WIDE_W'(d);
        if (take)
        begin
            st_next.seen_digit = 1'b1;
            if (!cur.overflowed)
            begin
                if (wide > aip_pkg::WIDE_W'(limit))
                    st_next.overflowed = 1'b1;
                else
                    st_next.accumulator = wide[aip_pkg::VALUE_W-1:0];
            end
        end

        cnt_sum = {1'b0, cur.char_count} + (aip_pkg::COUNT_BITS+1)'(inc);
        st_next.char_count = cnt_sum[aip_pkg::COUNT_BITS] ? '1 :
                             cnt_sum[aip_pkg::COUNT_BITS-1:0];

        if (cur.overflowed)
            fin_value = signed_mode ? (cur.negative ? aip_pkg::S_MIN_MAG : aip_pkg::S_MAX)
                                    : aip_pkg::U_MAX;
        else
            fin_value = cur.negative ? (aip_pkg::VALUE_W'(0) - cur.accumulator)
                                     : cur.accumulator;

        res.value      = cur.seen_digit ? fin_value : '0;
        res.overflow   = cur.seen_digit & cur.overflowed;
        res.any_digits = cur.seen_digit;
        res.consumed   = cur.seen_digit ? cur.char_count : '0;

        if (res_valid)
        begin
            st_next            = cur;
            st_next.phase      = aip_pkg::PH_DONE;
            if (numstart)
                st_next.work_radix = base_radix;
        end
    end

endmodule

// ===== design/ascii_integer_parser_top.sv =====
// ASCII integer parser: turns a stream of characters into 32-bit integers.
//
// Input stream (s_*): one character per beat in s_tdata[7:0]; s_tuser high
// marks the first character of a new string and restarts the parse, dropping
// any parse still open. Characters that arrive while no parse is open are
// ignored. Leading whitespace, one sign and, in auto or hex radix, a 0x prefix are taken.
// Output stream (m_*): one beat per number, sent on the character that ends
// it (any character that cannot continue the number, including NUL).
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write radix (0) and
// signed_mode (1); write only while the block is idle.
//
// Throughput: one character per cycle while no result stall holds the input,
// set by the single 32x6 multiply-add in aip_step between the input register
// and the state/result registers. Path: the ending character is loaded into
// the input register, then into the result register, which raises m_tvalid.
// Reset: no parse open, radix 10, signed mode, both streams empty.
// Stall: while m_tready is low and a result waits, the input register holds
// its character and s_tready drops once that register is full.
module ascii_integer_parser_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [aip_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] char_in
    input  logic                                 s_tuser,   // [0] first
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] value, [32] overflow, [33] any_digits, [49:34] consumed, rest zero
    output logic [aip_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [aip_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [aip_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic                                in_valid_reg;
    logic [aip_pkg::CHAR_W-1:0]          in_char_reg;
    logic                                in_first_reg;
    aip_pkg::parse_state_t               state_reg;
    aip_pkg::parse_state_t               state_next;
    logic [aip_pkg::RADIX_W-1:0]         radix_reg;
    logic                                signed_mode_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    aip_pkg::result_t                    out_res_reg;
    aip_pkg::result_t                    step_res;
    logic                                step_res_valid;
    logic                                out_free;
    logic                                advance;

    aip_step u_step (
        .st          (state_reg),
        .char_in     (in_char_reg),
        .first       (in_first_reg),
        .radix       (radix_reg),
        .signed_mode (signed_mode_reg),
        .st_next     (state_next),
        .res_valid   (step_res_valid),
        .res         (step_res)
    );

    // advance the held character only when the result register can take a beat
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && step_res_valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.phase       <= aip_pkg::PH_DONE;
            state_reg.negative    <= 1'b0;
            state_reg.accumulator <= '0;
            state_reg.work_radix  <= aip_pkg::RADIX_DEC;
            state_reg.overflowed  <= 1'b0;
            state_reg.seen_digit  <= 1'b0;
            state_reg.char_count  <= '0;
            radix_reg       <= aip_pkg::RADIX_DEC;
            signed_mode_reg <= 1'b1;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    aip_pkg::CFG_RADIX:  radix_reg       <= cfg_wdata;
                    aip_pkg::CFG_SIGNED: signed_mode_reg <= cfg_wdata[0];
                endcase
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg  <= s_tdata[aip_pkg::CHAR_W-1:0];
            in_first_reg <= s_tuser;
        end
        if (advance && step_res_valid)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = aip_pkg::OUT_TDATA_W'(out_res_reg);

endmodule

// ===== design/aip_checker.sv =====
module aip_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [aip_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [aip_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [aip_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [aip_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    aip_pkg::result_t res;
    assign res = m_tdata[aip_pkg::RESULT_W-1:0];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // no digits means an all-zero result
    a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.any_digits |->
            res.value == '0 && !res.overflow && res.consumed == '0)
        else $error("result without digits is not zero");

    // a digit always counts at least one character
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.any_digits |-> res.consumed != '0)
        else $error("digits seen but nothing consumed");

    // a result is born from an accepted character, or follows a held input
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 1)
                           || $past(!s_tready, 2))
        else $error("result beat without a preceding character");

    // padding above the result stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[aip_pkg::OUT_TDATA_W-1:aip_pkg::RESULT_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (.*);

// ===== dv/ascii_integer_parser_checker.sv =====
`timescale 1ns / 100ps

module ascii_integer_parser_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [aip_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] char_in
    input  logic                               s_tuser,   // [0] first
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] value, [32] overflow, [33] any_digits, [49:34] consumed, rest zero
    input  logic [aip_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [aip_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [aip_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                 pending,
    output int                                 errors
);
    import aip_pkg::*;

    localparam int NOT_A_DIGIT = 99;
    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    // shadow of the parse state and of the two registers
    phase_t                 ph = PH_DONE;
    logic                   neg = 1'b0;
    logic                   ovf = 1'b0;
    logic                   seen = 1'b0;
    logic [VALUE_W-1:0]     acc = '0;
    int                     wrad = 10;
    logic [COUNT_BITS-1:0]  cnt = '0;
    logic [RADIX_W-1:0]     radix_reg = RADIX_DEC;
    logic                   signed_reg = 1'b1;

    result_t                expected_numbers[$];
    int                     err_count = 0;
    int                     waiting = 0;

    assign errors  = err_count;
    assign pending = waiting;

    function automatic int char_digit(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ)
            return int'(c) - int'(CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LZ)
            return int'(c) - int'(CH_LA) + 10;
        return NOT_A_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic bump(input int n);
        longint unsigned total;
        total = 64'(cnt) + 64'(n);
        cnt = (total > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(total);
    endtask

    // multiply-add in 64 bits; saturation is decided against the active limit
    task automatic fold_digit(input int d);
        logic [63:0] wide;
        logic [63:0] limit;
        seen = 1'b1;
        if (ovf)
            return;
        if (signed_reg)
            limit = neg ? 64'(S_MIN_MAG) : 64'(S_MAX);
        else
            limit = 64'(U_MAX);
        wide = 64'(acc) * 64'(wrad) + 64'(d);
        if (wide > limit)
            ovf = 1'b1;
        else
            acc = wide[VALUE_W-1:0];
    endtask

    task automatic close_number();
        result_t            r;
        logic [VALUE_W-1:0] v;
        if (ovf)
            v = signed_reg ? (neg ? S_MIN_MAG : S_MAX) : U_MAX;
        else
            v = neg ? (32'd0 - acc) : acc;
        r.value      = seen ? v : '0;
        r.overflow   = seen & ovf;
        r.any_digits = seen;
        r.consumed   = seen ? cnt : '0;
        expected_numbers.push_back(r);
        ph = PH_DONE;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic f);
        int d;
        int r;
        d = char_digit(c);
        if (f)
        begin
            ph   = PH_SPACE;
            neg  = 1'b0;
            acc  = '0;
            ovf  = 1'b0;
            seen = 1'b0;
            cnt  = '0;
        end
        if (ph == PH_SPACE)
        begin
            if (is_blank(c))
            begin
                bump(1);
                return;
            end
            if (c == CH_MINUS || c == CH_PLUS)
            begin
                neg = (c == CH_MINUS);
                bump(1);
                ph = PH_SIGN;
                return;
            end
            ph = PH_SIGN;
        end
        if (ph == PH_SIGN)
        begin
            // the working base is latched here, at the start of the number
            r = (radix_reg > RADIX_MAX) ? int'(RADIX_MAX) : int'(radix_reg);
            if (c == CH_ZERO && (r == int'(RADIX_AUTO) || r == int'(RADIX_HEX)))
            begin
                wrad = (r == int'(RADIX_AUTO)) ? int'(RADIX_OCT) : int'(RADIX_HEX);
                seen = 1'b1;
                bump(1);
                ph = PH_ZERO;
                return;
            end
            wrad = (r == int'(RADIX_AUTO)) ? int'(RADIX_DEC) : r;
            if (d < wrad)
            begin
                fold_digit(d);
                bump(1);
                ph = PH_DIGITS;
            end
            else
                close_number();
            return;
        end
        if (ph == PH_ZERO)
        begin
            if (c == CH_LX || c == CH_UX)
            begin
                wrad = int'(RADIX_HEX);
                ph = PH_HEXPFX;
                return;
            end
            ph = PH_DIGITS;
        end
        case (ph)
            PH_DIGITS:
            begin
                if (d < wrad)
                begin
                    fold_digit(d);
                    bump(1);
                end
                else
                    close_number();
            end
            PH_HEXPFX:
            begin
                // the prefix letter is only counted once a hex digit follows
                if (d < 16)
                begin
                    fold_digit(d);
                    bump(2);
                    ph = PH_DIGITS;
                end
                else
                    close_number();
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph         = PH_DONE;
            neg        = 1'b0;
            acc        = '0;
            wrad       = int'(RADIX_DEC);
            ovf        = 1'b0;
            seen       = 1'b0;
            cnt        = '0;
            radix_reg  = RADIX_DEC;
            signed_reg = 1'b1;
            expected_numbers.delete();
            waiting    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_numbers.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none actual %0h",
                             $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    result_t want;
                    result_t got;
                    want = expected_numbers.pop_front();
                    got  = m_tdata[RESULT_W-1:0];
                    check_field("value", 64'(want.value), 64'(got.value));
                    check_field("overflow", 64'(want.overflow), 64'(got.overflow));
                    check_field("any_digits", 64'(want.any_digits), 64'(got.any_digits));
                    check_field("consumed", 64'(want.consumed), 64'(got.consumed));
                    check_field("padding", 64'd0, 64'(m_tdata[OUT_TDATA_W-1:RESULT_W]));
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_addr == CFG_RADIX)
                    radix_reg = cfg_wdata[RADIX_W-1:0];
                else if (cfg_addr == CFG_SIGNED)
                    signed_reg = cfg_wdata[0];
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata[CHAR_W-1:0], s_tuser);
            waiting = expected_numbers.size();
        end
    end

endmodule

// ===== dv/ascii_integer_parser_top_tb.sv =====
`timescale 1ns / 100ps

module ascii_integer_parser_top_tb;
    import aip_pkg::*;

    localparam int N_RANDOM     = 300;
    localparam int STALL_LIMIT  = 2000;  // idle cycles allowed before the run is declared hung
    localparam int DRAIN_CYCLES = 8;     // well past the input and result registers of the block
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

    // all block inputs start at a known value
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tready  = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tready;
    logic                    m_tvalid;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int                      pending;
    int                      errors;
    int                      quiet = 0;
    int                      chars_sent = 0;
    bit                      steady = 1'b0;     // high: neither side inserts gaps
    logic [RADIX_W-1:0]      cur_radix = RADIX_DEC;

    ascii_integer_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ascii_integer_parser_checker u_parse_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Back-pressure the result stream: drop tready with a chance of about 37
    // in a hundred, except during the steady stretch.
    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 37);
    end

    // Watchdog: count cycles with no beat on either stream, end the run when
    // the count hits the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Send one character beat. Called at a falling edge; returns at the
    // falling edge after the beat was taken, leaving tvalid for the next
    // call to decide, so tvalid gets one assignment per edge.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic f);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        chars_sent++;
        @(negedge clk);
    endtask

    // Send a text; the first character optionally restarts the parse.
    task automatic send_chars(input string s, input bit f);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], f && (i == 0));
    endtask

    // A complete string: restart, text, NUL terminator.
    task automatic send_number(input string s);
        send_chars(s, 1'b1);
        send_char(CH_NUL, 1'b0);
    endtask

    // Write one register while the block is idle: hold the input stream,
    // wait for every expected result, then let the pipeline drain.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input logic [RADIX_W-1:0] r, input logic sgn);
        write_reg(CFG_RADIX, CFG_DATA_W'(r));
        write_reg(CFG_SIGNED, CFG_DATA_W'(sgn));
        cur_radix = r;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int d);
        if (d < 10)
            return CHAR_W'(int'(CH_ZERO) + d);
        // mix the letter case
        return CHAR_W'(($urandom_range(1) ? int'(CH_UA) : int'(CH_LA)) + d - 10);
    endfunction

    // Random well-formed number for the current radix: blanks, sign,
    // prefix where the radix allows it, digits, then a random terminator.
    task automatic send_random_number();
        int  r;
        int  base;
        int  mode;
        int  ndig;
        int  d;
        bit  lead;
        logic [CHAR_W-1:0] c;
        r    = (cur_radix > RADIX_MAX) ? int'(RADIX_MAX) : int'(cur_radix);
        base = (r == int'(RADIX_AUTO)) ? int'(RADIX_DEC) : r;
        mode = 0;
        lead = 1'b1;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
        begin
            c = ($urandom_range(5) == 0) ? CH_SPACE : CHAR_W'(int'(CH_TAB) + $urandom_range(4));
            send_char(c, lead);
            lead = 1'b0;
        end
        case ($urandom_range(3))
            1: begin send_char(CH_PLUS, lead); lead = 1'b0; end
            2: begin send_char(CH_MINUS, lead); lead = 1'b0; end
            default: ;
        endcase
        // auto radix: pick decimal, octal or hex; hex radix: prefix sometimes
        if (r == int'(RADIX_AUTO))
            mode = $urandom_range(2);
        else if (r == int'(RADIX_HEX) && $urandom_range(1))
            mode = 2;
        if (mode == 1)
        begin
            send_char(CH_ZERO, lead);
            lead = 1'b0;
            base = int'(RADIX_OCT);
        end
        else if (mode == 2)
        begin
            send_char(CH_ZERO, lead);
            send_char($urandom_range(1) ? CH_LX : CH_UX, 1'b0);
            lead = 1'b0;
            base = int'(RADIX_HEX);
        end
        // mostly short numbers, some long enough to saturate
        ndig = ($urandom_range(3) == 0) ? $urandom_range(8, 34) : $urandom_range(1, 6);
        for (int i = 0; i < ndig; i++)
        begin
            d = $urandom_range(base - 1);
            if (r == int'(RADIX_AUTO) && mode == 0 && i == 0)
                d = $urandom_range(1, 9);
            send_char(digit_char(d), lead);
            lead = 1'b0;
        end
        send_char($urandom_range(1) ? CH_NUL : CHAR_W'($urandom_range(255)), lead);
    endtask

    initial
    begin
        int mark;
        int strings;
        int rr;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // characters before any first flag are ignored
        send_char(CH_NINE, 1'b0);
        send_char(CH_NUL, 1'b0);

        set_mode(RADIX_DEC, 1'b1);
        send_number("123");
        send_number("2147483647");
        send_number("2147483648");
        send_number("-2147483648");
        send_number("-2147483649");
        send_number("abc");
        send_number("+");
        send_char(CH_NUL, 1'b1);

        // every blank character, then a sign and digits ended by a letter
        send_char(CH_TAB, 1'b1);
        for (int b = int'(CH_TAB) + 1; b <= int'(CH_CR); b++)
            send_char(CHAR_W'(b), 1'b0);
        send_chars(" -42x", 1'b0);

        // restart while a parse is open: the first parse is dropped
        send_chars("12", 1'b1);
        send_number("34");
        // after the number ends, further characters are ignored
        send_chars("5x9", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_chars("9", 1'b1);
        send_char(8'hFF, 1'b0);

        // switch sign mode and radix in the middle of an open number
        send_chars("-21474836", 1'b1);
        set_mode(RADIX_HEX, 1'b0);
        send_chars("49", 1'b0);
        send_char(CH_NUL, 1'b0);

        set_mode(RADIX_HEX, 1'b1);
        send_number("0x1F");
        send_number("0X");
        send_number("0xg");
        send_number("ffffffff");
        send_number("-0x80000000");
        send_number("7FfFfFfF");

        set_mode(RADIX_AUTO, 1'b1);
        send_number("0755");
        send_number("0x1a");
        send_number("123");
        send_number("08");

        set_mode(RADIX_W'(1), 1'b1);
        send_number("000");
        send_number("01");

        set_mode(RADIX_MAX, 1'b1);
        send_number("zZ");
        set_mode(RADIX_W'(63), 1'b0);
        send_number("zz");

        set_mode(RADIX_DEC, 1'b0);
        send_number("-1");
        send_number("4294967295");
        send_number("4294967296");
        send_number("-4294967295");
        set_mode(RADIX_W'(2), 1'b0);
        send_number("-101");

        // random part: mostly numbers, some noise, new settings now and then
        mark    = chars_sent;
        strings = 0;
        while (chars_sent - mark < N_RANDOM)
        begin
            steady = (chars_sent - mark >= 100) && (chars_sent - mark < 200);
            if (strings % 12 == 0)
            begin
                case ($urandom_range(7))
                    0: rr = int'(RADIX_AUTO);
                    1: rr = 1;
                    2: rr = 2;
                    3: rr = int'(RADIX_OCT);
                    4: rr = int'(RADIX_DEC);
                    5: rr = int'(RADIX_HEX);
                    6: rr = int'(RADIX_MAX);
                    default: rr = $urandom_range(63);
                endcase
                set_mode(RADIX_W'(rr), 1'($urandom_range(1)));
            end
            if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(3) == 0));
            end
            else
                send_random_number();
            strings++;
        end

        // drain: wait for every result, then wait DRAIN_CYCLES for strays
        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/aip_pkg.sv
design/aip_step.sv
design/ascii_integer_parser_top.sv
design/aip_checker.sv
dv/ascii_integer_parser_checker.sv
dv/ascii_integer_parser_top_tb.sv
